>>> sv/kped_pkg.sv
// Shared types and constants for the keypad press event detector.
package kped_pkg;

    localparam int NUM_BUTTONS = 16;
    localparam int LANES       = (NUM_BUTTONS < 16) ? NUM_BUTTONS : 16;

    localparam int MAP_W   = 16;
    localparam int TIME_W  = 32;
    localparam int THR_W   = 16;
    localparam int IDX_W   = 4;
    localparam int CFG_AW  = 2;
    localparam int CFG_DW  = 16;
    localparam int S_DW    = 48;
    localparam int M_DW    = 8;

    localparam logic [CFG_AW-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_LONG_MASK  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_BTN_MASK   = 2'd2;

    localparam logic [THR_W-1:0]  THRESHOLD_RST  = 16'd1000;
    localparam logic [MAP_W-1:0]  LONG_MASK_RST  = 16'hFFFF;
    localparam logic [MAP_W-1:0]  BTN_MASK_RST   = 16'hFFFF;

    typedef enum logic [1:0] {
        EV_PRESS   = 2'd0,
        EV_HELD    = 2'd1,
        EV_RELEASE = 2'd2
    } t_kind;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } t_state;

    typedef struct packed {
        logic  hit;
        t_kind kind;
        logic  lng;
    } t_lane_res;

    typedef struct packed {
        logic             hit;
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        logic             lng;
    } t_pick;

endpackage

>>> sv/keypad_press_event_detector.sv
// Keypad press event detector top level.
//
// Input stream: one keypad scan per transfer, tdata = pressed_map [15:0],
// time_ms [47:16]. Output stream: at most one event per scan, tdata =
// event_kind [1:0], button_index [5:2], long_flag [6], bit 7 zero.
// Config port: i_cfg_we writes i_cfg_wdata to register i_cfg_addr
// (0 threshold, 1 long-press mask, 2 button enable mask); write only when idle.
//
// A scan is registered when taken and all buttons are checked at once in the
// next, one lane per button; the lowest enabled button with an event wins.
// The event enters the output register when evaluation completes, which waits
// while a stalled output register holds an event. A new scan is taken only once
// the last has left evaluation; the per-button lanes and the merge are combinational.
//
// Reset clears all levels to released, loads the register defaults and
// empties the output register. If the receiver stalls, the pending event
// holds; the next scan is still taken but waits in evaluation until the
// output register frees up, if it has an event of its own.
module keypad_press_event_detector (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [kped_pkg::S_DW-1:0]     s_axis_tdata,  // pressed_map, time_ms
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [kped_pkg::M_DW-1:0]     m_axis_tdata,  // event_kind, button_index, long_flag
    input  logic                          i_cfg_we,
    input  logic [kped_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  logic [kped_pkg::CFG_DW-1:0]   i_cfg_wdata
);
    import kped_pkg::*;

    t_state              r_state, n_state;
    logic [THR_W-1:0]    r_threshold;
    logic [MAP_W-1:0]    r_long_mask;
    logic [MAP_W-1:0]    r_btn_mask;
    logic [MAP_W-1:0]    r_map;
    logic [TIME_W-1:0]   r_now;
    logic [LANES-1:0]    r_level;
    logic [TIME_W-1:0]   r_start [LANES];
    logic                r_out_valid;
    t_pick               r_out;

    t_lane_res           lane_res [LANES];
    t_pick               pick;
    logic                advance;
    logic                take;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_long_mask <= LONG_MASK_RST;
            r_btn_mask  <= BTN_MASK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_THRESHOLD: r_threshold <= i_cfg_wdata;
                CFG_LONG_MASK: r_long_mask <= i_cfg_wdata;
                CFG_BTN_MASK:  r_btn_mask  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // scan capture
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_map <= s_axis_tdata[MAP_W-1:0];
            r_now <= s_axis_tdata[MAP_W +: TIME_W];
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        kped_lane u_lane (
            .i_en        (r_btn_mask[g]),
            .i_long_en   (r_long_mask[g]),
            .i_pressed   (r_map[g]),
            .i_level     (r_level[g]),
            .i_start     (r_start[g]),
            .i_now       (r_now),
            .i_threshold (r_threshold),
            .o_res       (lane_res[g])
        );

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_level[g] <= 1'b0;
            end else if (advance && pick.hit && pick.idx == IDX_W'(g)) begin
                if (pick.kind == EV_PRESS) begin
                    r_level[g] <= 1'b1;
                end else if (pick.kind == EV_RELEASE) begin
                    r_level[g] <= 1'b0;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance && pick.hit && pick.idx == IDX_W'(g) && pick.kind == EV_PRESS) begin
                r_start[g] <= r_now;
            end
        end
    end

    kped_merge u_merge (
        .i_lanes (lane_res),
        .o_pick  (pick)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (s_axis_tvalid) n_state = ST_EVAL;
            ST_EVAL: if (advance)       n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        advance       = 1'b0;
        unique case (r_state)
            ST_IDLE: s_axis_tready = 1'b1;
            ST_EVAL: advance = !pick.hit || !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    assign take = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && pick.hit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && pick.hit) begin
            r_out <= pick;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out.lng, r_out.idx, r_out.kind};

endmodule

>>> sv/kped_lane.sv
// One button lane: finds the event this button would report for the current scan.
module kped_lane (
    input  logic                          i_en,
    input  logic                          i_long_en,
    input  logic                          i_pressed,
    input  logic                          i_level,
    input  logic [kped_pkg::TIME_W-1:0]   i_start,
    input  logic [kped_pkg::TIME_W-1:0]   i_now,
    input  logic [kped_pkg::THR_W-1:0]    i_threshold,
    output kped_pkg::t_lane_res           o_res
);
    import kped_pkg::*;

    logic [TIME_W-1:0] hold;
    logic              reached;

    assign hold    = i_now - i_start;
    assign reached = hold >= {{(TIME_W-THR_W){1'b0}}, i_threshold};

    always_comb begin
        o_res.hit  = 1'b0;
        o_res.kind = EV_PRESS;
        o_res.lng  = 1'b0;
        if (i_en) begin
            if (!i_level) begin
                o_res.hit  = i_pressed;
                o_res.kind = EV_PRESS;
            end else if (i_pressed) begin
                o_res.hit  = reached;
                o_res.kind = EV_HELD;
                o_res.lng  = i_long_en;
            end else begin
                o_res.hit  = 1'b1;
                o_res.kind = EV_RELEASE;
                o_res.lng  = reached & i_long_en;
            end
        end
    end

endmodule

>>> sv/kped_merge.sv
// Merge stage: picks the lowest-index lane that found an event.
module kped_merge (
    input  kped_pkg::t_lane_res i_lanes [kped_pkg::LANES],
    output kped_pkg::t_pick     o_pick
);
    import kped_pkg::*;

    always_comb begin
        o_pick.hit  = 1'b0;
        o_pick.kind = EV_PRESS;
        o_pick.idx  = '0;
        o_pick.lng  = 1'b0;
        for (int i = LANES - 1; i >= 0; i--) begin
            if (i_lanes[i].hit) begin
                o_pick.hit  = 1'b1;
                o_pick.kind = i_lanes[i].kind;
                o_pick.idx  = IDX_W'(i);
                o_pick.lng  = i_lanes[i].lng;
            end
        end
    end

endmodule

>>> sv/kped_checker.sv
// Port-level checks for the keypad press event detector, bound to the top level.
module kped_port_checks (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [kped_pkg::M_DW-1:0]     m_axis_tdata
);
    import kped_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled output transfer changed");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("scan taken while previous scan still evaluating");

    a_kind_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 && !m_axis_tdata[7])
        else $error("bad event code or padding");

    a_press_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == EV_PRESS |-> !m_axis_tdata[6])
        else $error("new press flagged long");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind keypad_press_event_detector kped_port_checks u_kped_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> bench/kped_checker.sv
// Checker: predicts keypad events from observed scans and compares the output stream.
`timescale 1ns / 1ps
module kped_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_scan_valid,
    input  logic                        i_scan_ready,
    input  logic [kped_pkg::S_DW-1:0]   i_scan_data,
    input  logic                        i_event_valid,
    input  logic                        i_event_ready,
    input  logic [kped_pkg::M_DW-1:0]   i_event_data,
    input  logic                        i_cfg_we,
    input  logic [kped_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [kped_pkg::CFG_DW-1:0] i_cfg_wdata,
    output int                          o_fail_count,
    output int                          o_pending
);
    import kped_pkg::*;

    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] idx;
        logic             lng;
    } t_key_event;

    logic [THR_W-1:0]  threshold;
    logic [MAP_W-1:0]  long_mask;
    logic [MAP_W-1:0]  btn_mask;
    logic [LANES-1:0]  key_down;
    logic [TIME_W-1:0] press_time [LANES];
    t_key_event        events_q [$];
    int                fails = 0;

    function automatic bit next_key_event(input logic [MAP_W-1:0] map,
                                          input logic [TIME_W-1:0] now,
                                          output t_key_event ev);
        logic [TIME_W-1:0] hold;
        logic              reached;
        ev = '0;
        for (int b = 0; b < LANES; b++) begin
            if (!btn_mask[b]) continue;
            ev.idx = IDX_W'(b);
            if (!key_down[b]) begin
                if (map[b]) begin
                    press_time[b] = now;
                    key_down[b]   = 1'b1;
                    ev.kind       = EV_PRESS;
                    ev.lng        = 1'b0;
                    return 1'b1;
                end
                continue;
            end
            hold    = now - press_time[b];
            reached = hold >= {16'd0, threshold};
            if (map[b]) begin
                if (reached) begin
                    ev.kind = EV_HELD;
                    ev.lng  = long_mask[b];
                    return 1'b1;
                end
                continue;
            end
            key_down[b] = 1'b0;
            ev.kind     = EV_RELEASE;
            ev.lng      = reached & long_mask[b];
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_key_event got;
        t_key_event want;
        t_key_event ev;
        if (!i_rst_n) begin
            threshold = THRESHOLD_RST;
            long_mask = LONG_MASK_RST;
            btn_mask  = BTN_MASK_RST;
            key_down  = '0;
            events_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_THRESHOLD: threshold = i_cfg_wdata;
                    CFG_LONG_MASK: long_mask = i_cfg_wdata;
                    CFG_BTN_MASK:  btn_mask  = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_event_valid && i_event_ready) begin
                got.kind = t_kind'(i_event_data[1:0]);
                got.idx  = i_event_data[5:2];
                got.lng  = i_event_data[6];
                if (events_q.size() == 0) begin
                    $error("unexpected event transfer: event_kind %0d button_index %0d long_flag %0d",
                           got.kind, got.idx, got.lng);
                    fails++;
                end else begin
                    want = events_q.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("event_kind: expected %0d, actual %0d", want.kind, got.kind);
                        fails++;
                    end
                    if (got.idx !== want.idx) begin
                        $error("button_index: expected %0d, actual %0d", want.idx, got.idx);
                        fails++;
                    end
                    if (got.lng !== want.lng) begin
                        $error("long_flag: expected %0d, actual %0d", want.lng, got.lng);
                        fails++;
                    end
                end
            end
            if (i_scan_valid && i_scan_ready) begin
                if (next_key_event(i_scan_data[MAP_W-1:0], i_scan_data[MAP_W +: TIME_W], ev))
                    events_q.push_back(ev);
            end
        end
        o_fail_count <= fails;
        o_pending    <= events_q.size();
    end

endmodule

>>> bench/tb_top.sv
// Testbench top: drives keypad scans and register writes, gives the verdict.
`timescale 1ns / 1ps
module tb_top;
    import kped_pkg::*;

    localparam logic [CFG_AW-1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_ITEMS   = 300;
    localparam int NUM_PHASES    = 7;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [S_DW-1:0]   s_axis_tdata  = '0;   // pressed_map [15:0], time_ms [47:16]
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [M_DW-1:0]   m_axis_tdata;         // event_kind [1:0], button_index [5:2], long_flag [6]
    logic              i_cfg_we      = 1'b0;
    logic [CFG_AW-1:0] i_cfg_addr    = '0;
    logic [CFG_DW-1:0] i_cfg_wdata   = '0;

    int fail_count;
    int pending_events;
    bit steady = 1'b0;
    int ready_hold = 0;

    keypad_press_event_detector u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    kped_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scan_valid  (s_axis_tvalid),
        .i_scan_ready  (s_axis_tready),
        .i_scan_data   (s_axis_tdata),
        .i_event_valid (m_axis_tvalid),
        .i_event_ready (m_axis_tready),
        .i_event_data  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending_events)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // event consumer with random back-pressure
    always @(posedge i_clk) begin
        int stall;
        if (steady) begin
            m_axis_tready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_axis_tready) begin
            stall = idle_len();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                ready_hold    <= stall - 1;
            end
        end else begin
            m_axis_tready <= 1'b1;
            ready_hold    <= $urandom_range(0, 12);
        end
    end

    task automatic send_scan(input logic [MAP_W-1:0] map, input logic [TIME_W-1:0] now);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, map};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_events != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [MAP_W-1:0]  keys;
        logic [TIME_W-1:0] clock_ms;
        logic [THR_W-1:0]  thr;
        logic [MAP_W-1:0]  lmask;
        logic [MAP_W-1:0]  bmask;
        int unsigned       thr_now;
        int                roll;
        int                n_items;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset config: threshold 1000, all buttons enabled
        send_scan(16'h0000, 32'h0000_0000);
        send_scan(16'h8001, 32'h0000_0005);
        send_scan(16'h8001, 32'h0000_0006);   // button 0 short hold, button 15 press
        send_scan(16'h8001, 32'h0000_03ED);   // button 0 exactly at threshold
        send_scan(16'h8000, 32'h0000_03EE);
        send_scan(16'h8000, 32'h0000_03EC);   // button 15 just below threshold
        send_scan(16'h0000, 32'h0000_03ED);
        send_scan(16'h0002, 32'hFFFF_FF00);
        send_scan(16'h0002, 32'h0000_02F0);   // hold across timestamp wrap
        send_scan(16'h0000, 32'h0000_02F1);
        send_scan(16'hFFFF, 32'hFFFF_FFFF);
        send_scan(16'hFFFF, 32'h5555_AAAA);
        send_scan(16'h0000, 32'hAAAA_5555);
        send_scan(16'h0000, 32'hAAAA_5556);

        keys     = 16'h0000;
        clock_ms = 32'hAAAA_6000;
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            case (ph)
                0: begin thr = 16'd1;     lmask = 16'hFFFF;     bmask = 16'hFFFF;     end
                1: begin thr = 16'hFFFF;  lmask = 16'($urandom); bmask = 16'hFFFF;     end
                2: begin thr = 16'd0;     lmask = 16'h5A5A;     bmask = 16'($urandom); end
                3: begin
                    thr   = 16'($urandom_range(2, 400));
                    lmask = 16'h0000;
                    bmask = 16'hFFFF;
                end
                4: begin thr = THRESHOLD_RST; lmask = 16'hFFFF; bmask = 16'h0000;     end
                5: begin
                    thr   = 16'($urandom_range(1, 65535));
                    lmask = 16'($urandom);
                    bmask = 16'($urandom);
                end
                default: begin thr = 16'd50; lmask = 16'hFFFF; bmask = 16'h8001;   end
            endcase
            write_reg(CFG_THRESHOLD, thr);
            write_reg(CFG_LONG_MASK, lmask);
            write_reg(CFG_BTN_MASK, bmask);
            if (ph == 5) write_reg(CFG_SPARE, 16'($urandom));
            thr_now = thr;
            steady  <= (ph == 0 || ph == 6);
            n_items = (ph == 4) ? 25 : PHASE_ITEMS;

            repeat (n_items) begin
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    keys = 16'h0000;
                else if (roll < 12)
                    keys = 16'($urandom);
                else if (roll < 70)
                    keys ^= 16'(1) << $urandom_range(0, 15);

                roll = $urandom_range(0, 99);
                if (roll < 80)
                    clock_ms += $urandom_range(0, thr_now / 4 + 3);
                else if (roll < 95)
                    clock_ms += $urandom_range(thr_now / 2, thr_now * 2 + 1);
                else
                    clock_ms = $urandom;

                send_scan(keys, clock_ms);
                if ($urandom_range(0, 99) == 0) wait_drained();
            end
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
